FILE: sv/oets_pkg.sv
`timescale 1ns / 1ps

package oets_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ELEMS_DEF = 64;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_SORT = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // write incoming word at the fill index
        logic sort;   // run one compare-swap phase
        logic odd;    // phase parity: pairs (1,2),(3,4),...
        logic shift;  // pop head, move every cell down one
    } t_dp_cmd;

endpackage

FILE: sv/oets_ctrl.sv
`timescale 1ns / 1ps

module oets_ctrl
    import oets_pkg::*;
#(
    parameter int MAX_ELEMS = MAX_ELEMS_DEF,
    parameter int CNT_W     = $clog2(MAX_ELEMS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_is_last,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_end_of_run,
    output logic             o_overflow,
    output t_dp_cmd          o_cmd,
    output logic [CNT_W-1:0] o_count
);

    localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_ELEMS);
    localparam logic [CNT_W-1:0] One    = CNT_W'(1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_phase, n_phase;
    logic             r_dropped, n_dropped;
    logic             in_acc;
    logic             out_acc;

    assign o_in_ready   = (r_state == S_LOAD);
    assign o_out_valid  = (r_state == S_EMIT);
    assign o_end_of_run = (r_count == One);
    assign o_overflow   = r_dropped;
    assign o_count      = r_count;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_phase     = r_phase;
        n_dropped   = r_dropped;
        o_cmd       = '0;
        o_cmd.odd   = r_phase[0];
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (r_count < MaxCnt) begin
                        o_cmd.load = 1'b1;
                        n_count    = r_count + One;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_is_last) begin
                        n_state = S_SORT;
                        n_phase = '0;
                    end
                end
            end
            S_SORT: begin
                o_cmd.sort = 1'b1;
                n_phase    = r_phase + One;
                // n phases for n elements
                if (r_phase == r_count - One) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_acc) begin
                    o_cmd.shift = 1'b1;
                    n_count     = r_count - One;
                    if (r_count == One) begin
                        n_state   = S_LOAD;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_phase   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_phase   <= n_phase;
            r_dropped <= n_dropped;
        end
    end

endmodule

FILE: sv/oets_dp.sv
`timescale 1ns / 1ps

module oets_dp
    import oets_pkg::*;
#(
    parameter int MAX_ELEMS = MAX_ELEMS_DEF,
    parameter int CNT_W     = $clog2(MAX_ELEMS + 1),
    parameter int IDX_W     = $clog2(MAX_ELEMS)
) (
    input  logic                     i_clk,
    input  t_dp_cmd                  i_cmd,
    input  logic [CNT_W-1:0]         i_count,
    input  logic signed [DATA_W-1:0] i_value,
    output logic signed [DATA_W-1:0] o_head
);

    // Row of cells; cell 0 is the output head
    logic signed [DATA_W-1:0] r_cell [MAX_ELEMS];
    logic signed [DATA_W-1:0] n_cell [MAX_ELEMS];

    assign o_head = r_cell[0];

    always_comb begin
        for (int i = 0; i < MAX_ELEMS; i++) begin
            n_cell[i] = r_cell[i];
        end
        if (i_cmd.load) begin
            for (int i = 0; i < MAX_ELEMS; i++) begin
                if (i_count[IDX_W-1:0] == IDX_W'(i)) begin
                    n_cell[i] = i_value;
                end
            end
        end
        if (i_cmd.sort) begin
            // pair (i, i+1) takes part only if both are inside the list
            for (int i = 0; i < MAX_ELEMS - 1; i++) begin
                if ((1'(i % 2) == i_cmd.odd) && (CNT_W'(i + 1) < i_count) &&
                    (r_cell[i] > r_cell[i+1])) begin
                    n_cell[i]   = r_cell[i+1];
                    n_cell[i+1] = r_cell[i];
                end
            end
        end
        if (i_cmd.shift) begin
            for (int i = 0; i < MAX_ELEMS - 1; i++) begin
                n_cell[i] = r_cell[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ELEMS; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

endmodule

FILE: sv/odd_even_transposition_sort_core.sv
`timescale 1ns / 1ps

// Odd-even transposition sorter for signed 32-bit words. Input words are
// stored in a row of MAX_ELEMS register cells, one word per cycle while
// i_in_ready is high; words past capacity are dropped and every result
// of that list then carries o_overflow. A word with i_is_last closes the
// list (a dropped last word still closes it). The cell row then runs n
// compare-swap phases, one per cycle, for a list of n words, with all
// neighbor pairs of a phase compared in parallel. The sorted words leave
// in ascending order from the head cell, one per accepted output word,
// and o_end_of_run marks the final one. Input is not taken while a
// list is sorting or emitting.
module odd_even_transposition_sort_core
    import oets_pkg::*;
#(
    parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_is_last,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_end_of_run,
    output logic                     o_overflow
);

    localparam int CNT_W = $clog2(MAX_ELEMS + 1);

    t_dp_cmd          cmd;
    logic [CNT_W-1:0] count;

    // Sequencing: load / sort phases / emit
    oets_ctrl #(
        .MAX_ELEMS (MAX_ELEMS),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_is_last    (i_is_last),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_end_of_run (o_end_of_run),
        .o_overflow   (o_overflow),
        .o_cmd        (cmd),
        .o_count      (count)
    );

    // Cell row with compare-swap network
    oets_dp #(
        .MAX_ELEMS (MAX_ELEMS),
        .CNT_W     (CNT_W)
    ) u_dp (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .i_count (count),
        .i_value (i_value),
        .o_head  (o_sorted_value)
    );

endmodule

FILE: sv/oets_checker.sv
`timescale 1ns / 1ps

module oets_checker
    import oets_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [DATA_W-1:0] o_sorted_value,
    input logic                     o_end_of_run,
    input logic                     o_overflow
);

    // Input is never taken while a list is being emitted
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && o_in_ready))
        else $error("input ready while emitting");

    // Results come out in ascending order within a run
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_end_of_run) |=>
        (o_out_valid && (o_sorted_value >= $past(o_sorted_value))))
        else $error("sorted words out of order");

    // Overflow flag is constant across one run
    a_ovf_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_end_of_run) |=>
        (o_overflow == $past(o_overflow)))
        else $error("overflow changed within a run");

    // Run ends after the marked word
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_end_of_run) |=> !o_out_valid)
        else $error("output word after end of run");

    // Stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_sorted_value)))
        else $error("stalled output word changed");

endmodule

bind odd_even_transposition_sort_core oets_checker u_oets_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_sorted_value (o_sorted_value),
    .o_end_of_run   (o_end_of_run),
    .o_overflow     (o_overflow)
);
